// File: design/syringe_pump_command_framer_defines.svh
// ----------------------------------------------------------------------------
// Syringe pump command framer: assertion macros
// Shared concurrent assertion forms; clock and reset are passed in.
// ----------------------------------------------------------------------------
`ifndef SYRINGE_PUMP_COMMAND_FRAMER_DEFINES_SVH
`define SYRINGE_PUMP_COMMAND_FRAMER_DEFINES_SVH

// Same-cycle implication.
`define SPCF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spcf assertion failed");

// Next-cycle implication.
`define SPCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spcf assertion failed");

`endif

// File: design/spcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_pkg
// Types and constants shared by the syringe pump command framer.
// ----------------------------------------------------------------------------
package spcf_pkg;

    localparam int FRAME_MAX = 11;
    localparam int LEN_W     = 4;

    typedef enum logic [3:0] {
        ACT_INIT_PROTO  = 4'd0,
        ACT_INIT_VALVE  = 4'd1,
        ACT_INIT_SYR    = 4'd2,
        ACT_GET_POS     = 4'd3,
        ACT_SET_POS     = 4'd4,
        ACT_GET_VEL     = 4'd5,
        ACT_SET_VEL     = 4'd6,
        ACT_GET_ANGLE   = 4'd7,
        ACT_SET_ANGLE   = 4'd8
    } t_action;

    // Register byte addresses
    localparam logic [1:0] REG_PUMP_ADDR = 2'd0;

    localparam logic [3:0]  PUMP_ADDR_RESET = 4'd1;

    // Value limits
    localparam logic [11:0] LIM_POS = 12'd3000;
    localparam logic [11:0] LIM_VEL = 12'd40;
    localparam logic [11:0] LIM_ANG = 12'd345;

    // ASCII
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SLASH = 8'h2F;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_LF    = 8'h0A;

    // Reciprocal multipliers for constant division (exact for 12-bit values)
    localparam logic [12:0] RECIP_10   = 13'd3277;  // >> 15
    localparam logic [12:0] RECIP_100  = 13'd5243;  // >> 19
    localparam logic [12:0] RECIP_1000 = 13'd4195;  // >> 22

    typedef struct packed {
        logic [3:0] d3;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
    } t_digits;

    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;  // byte 0 goes out first
        logic [LEN_W-1:0]          len;    // zero: command dropped
    } t_frame;

endpackage

// File: design/spcf_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_digits
// Splits a 12-bit value into four decimal digits by reciprocal multiplies.
// ----------------------------------------------------------------------------
module spcf_digits (
    input  logic [11:0]          i_value,
    output spcf_pkg::t_digits    o_digits
);
    import spcf_pkg::*;

    logic [24:0] w_p10;
    logic [24:0] w_p100;
    logic [24:0] w_p1000;
    logic [8:0]  w_q10;
    logic [5:0]  w_q100;
    logic [2:0]  w_q1000;
    logic [11:0] w_r0;
    logic [8:0]  w_r1;
    logic [5:0]  w_r2;

    assign w_p10   = {13'd0, i_value} * {12'd0, RECIP_10};
    assign w_p100  = {13'd0, i_value} * {12'd0, RECIP_100};
    assign w_p1000 = {13'd0, i_value} * {12'd0, RECIP_1000};

    assign w_q10   = w_p10[23:15];
    assign w_q100  = w_p100[24:19];
    assign w_q1000 = w_p1000[24:22];

    // value - 10*q, with 10*q as (q<<3)+(q<<1)
    assign w_r0 = i_value - ({w_q10, 3'd0} + {2'd0, w_q10, 1'b0});
    assign w_r1 = w_q10 - ({w_q100[5:0], 3'd0} + {2'd0, w_q100, 1'b0});
    assign w_r2 = w_q100 - ({w_q1000, 3'd0} + {2'd0, w_q1000, 1'b0});

    assign o_digits.d0 = w_r0[3:0];
    assign o_digits.d1 = w_r1[3:0];
    assign o_digits.d2 = w_r2[3:0];
    assign o_digits.d3 = {1'b0, w_q1000};

endmodule

// File: design/spcf_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_builder
// Assembles the full ASCII frame and its length for one command.
// ----------------------------------------------------------------------------
module spcf_builder (
    input  logic [3:0]        i_action,
    input  logic [11:0]       i_value,
    input  logic              i_direction,
    input  logic [3:0]        i_pump_address,
    output spcf_pkg::t_frame  o_frame
);
    import spcf_pkg::*;

    t_digits    w_dig;
    logic [7:0] w_addr;
    logic [7:0] w_a0;
    logic [7:0] w_a1;
    logic [7:0] w_a2;
    logic [7:0] w_a3;

    spcf_digits u_digits (
        .i_value  (i_value),
        .o_digits (w_dig)
    );

    assign w_addr = ASCII_ZERO + {4'd0, i_pump_address};
    assign w_a0   = ASCII_ZERO + {4'd0, w_dig.d0};
    assign w_a1   = ASCII_ZERO + {4'd0, w_dig.d1};
    assign w_a2   = ASCII_ZERO + {4'd0, w_dig.d2};
    assign w_a3   = ASCII_ZERO + {4'd0, w_dig.d3};

    always_comb begin
        o_frame          = '0;
        o_frame.bytes[0] = ASCII_SLASH;
        unique case (t_action'(i_action))
            ACT_INIT_PROTO: begin
                o_frame.bytes[1]  = "1";
                o_frame.bytes[2]  = "h";
                o_frame.bytes[3]  = "3";
                o_frame.bytes[4]  = "0";
                o_frame.bytes[5]  = "0";
                o_frame.bytes[6]  = "0";
                o_frame.bytes[7]  = "1";
                o_frame.bytes[8]  = "R";
                o_frame.bytes[9]  = ASCII_CR;
                o_frame.bytes[10] = ASCII_LF;
                o_frame.len       = 4'd11;
            end
            ACT_INIT_VALVE: begin
                o_frame.bytes[1]  = "1";
                o_frame.bytes[2]  = "h";
                o_frame.bytes[3]  = "2";
                o_frame.bytes[4]  = "0";
                o_frame.bytes[5]  = "0";
                o_frame.bytes[6]  = "0";
                o_frame.bytes[7]  = "0";
                o_frame.bytes[8]  = "R";
                o_frame.bytes[9]  = ASCII_CR;
                o_frame.bytes[10] = ASCII_LF;
                o_frame.len       = 4'd11;
            end
            ACT_INIT_SYR: begin
                o_frame.bytes[1]  = w_addr;
                o_frame.bytes[2]  = "h";
                o_frame.bytes[3]  = "1";
                o_frame.bytes[4]  = "0";
                o_frame.bytes[5]  = "0";
                o_frame.bytes[6]  = "0";
                o_frame.bytes[7]  = "0";
                o_frame.bytes[8]  = "R";
                o_frame.bytes[9]  = ASCII_CR;
                o_frame.bytes[10] = ASCII_LF;
                o_frame.len       = 4'd11;
            end
            ACT_GET_POS: begin
                o_frame.bytes[1] = w_addr;
                o_frame.bytes[2] = "?";
                o_frame.bytes[3] = "R";
                o_frame.bytes[4] = ASCII_CR;
                o_frame.bytes[5] = ASCII_LF;
                o_frame.len      = 4'd6;
            end
            ACT_SET_POS: begin
                if (i_value <= LIM_POS) begin
                    o_frame.bytes[1] = w_addr;
                    o_frame.bytes[2] = "A";
                    o_frame.bytes[3] = w_a3;
                    o_frame.bytes[4] = w_a2;
                    o_frame.bytes[5] = w_a1;
                    o_frame.bytes[6] = w_a0;
                    o_frame.bytes[7] = "R";
                    o_frame.bytes[8] = ASCII_CR;
                    o_frame.bytes[9] = ASCII_LF;
                    o_frame.len      = 4'd10;
                end
            end
            ACT_GET_VEL: begin
                o_frame.bytes[1] = w_addr;
                o_frame.bytes[2] = "?";
                o_frame.bytes[3] = "2";
                o_frame.bytes[4] = "R";
                o_frame.bytes[5] = ASCII_CR;
                o_frame.bytes[6] = ASCII_LF;
                o_frame.len      = 4'd7;
            end
            ACT_SET_VEL: begin
                if (i_value <= LIM_VEL) begin
                    o_frame.bytes[1] = w_addr;
                    o_frame.bytes[2] = "S";
                    o_frame.bytes[3] = w_a1;
                    o_frame.bytes[4] = w_a0;
                    o_frame.bytes[5] = "R";
                    o_frame.bytes[6] = ASCII_CR;
                    o_frame.bytes[7] = ASCII_LF;
                    o_frame.len      = 4'd8;
                end
            end
            ACT_GET_ANGLE: begin
                o_frame.bytes[1]  = w_addr;
                o_frame.bytes[2]  = "?";
                o_frame.bytes[3]  = "2";
                o_frame.bytes[4]  = "5";
                o_frame.bytes[5]  = "0";
                o_frame.bytes[6]  = "0";
                o_frame.bytes[7]  = "0";
                o_frame.bytes[8]  = "R";
                o_frame.bytes[9]  = ASCII_CR;
                o_frame.bytes[10] = ASCII_LF;
                o_frame.len       = 4'd11;
            end
            ACT_SET_ANGLE: begin
                if (i_value <= LIM_ANG) begin
                    o_frame.bytes[1]  = w_addr;
                    o_frame.bytes[2]  = "h";
                    o_frame.bytes[3]  = "2";
                    o_frame.bytes[4]  = i_direction ? "8" : "7";
                    o_frame.bytes[5]  = w_a2;
                    o_frame.bytes[6]  = w_a1;
                    o_frame.bytes[7]  = w_a0;
                    o_frame.bytes[8]  = "R";
                    o_frame.bytes[9]  = ASCII_CR;
                    o_frame.bytes[10] = ASCII_LF;
                    o_frame.len       = 4'd11;
                end
            end
            default: begin
                o_frame.len = '0;
            end
        endcase
    end

endmodule

// File: design/spcf_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcf_serializer
// Frame register that shifts one byte out per output beat.
// ----------------------------------------------------------------------------
module spcf_serializer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_valid,
    input  spcf_pkg::t_frame  i_frame,
    output logic              o_load_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_tx_byte,
    output logic              o_last_byte
);
    import spcf_pkg::*;

    logic                      r_valid;
    logic                      n_valid;
    logic [FRAME_MAX-1:0][7:0] r_bytes;
    logic [FRAME_MAX-1:0][7:0] n_bytes;
    logic [LEN_W-1:0]          r_left;
    logic [LEN_W-1:0]          n_left;
    logic                      w_fire;
    logic                      w_done;

    assign o_out_valid  = r_valid;
    assign o_tx_byte    = r_bytes[0];
    assign o_last_byte  = (r_left == LEN_W'(1));
    assign w_fire       = r_valid && i_out_ready;
    assign w_done       = w_fire && o_last_byte;
    assign o_load_ready = !r_valid || w_done;

    always_comb begin
        n_valid = r_valid;
        n_bytes = r_bytes;
        n_left  = r_left;
        priority if (i_load_valid && o_load_ready) begin
            n_valid = 1'b1;
            n_bytes = i_frame.bytes;
            n_left  = i_frame.len;
        end else if (w_done) begin
            n_valid = 1'b0;
        end else if (w_fire) begin
            n_bytes = r_bytes >> 8;
            n_left  = r_left - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else begin
            r_valid <= n_valid;
            r_left  <= n_left;
        end
        r_bytes <= n_bytes;
    end

endmodule

// File: design/syringe_pump_command_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syringe_pump_command_framer
// Turns pump commands into ASCII serial frames, one byte per output beat.
// ----------------------------------------------------------------------------
// Each accepted command produces its whole frame ("/", address digit, body,
// CR LF) as 6 to 11 output beats, one per cycle while o_out_valid and
// i_out_ready are high; o_last_byte marks the line feed. A set command whose
// value is over its limit, or an unused action code, produces no beats and
// is consumed without waiting for the frame register. Throughput is set by
// the frame register that shifts out one byte per beat; a second command
// waits in the command register while the current frame drains, so frames
// leave back to back. The pump address register (byte address 0, reset 1)
// sits on the APB port.
module syringe_pump_command_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_action,
    input  logic [11:0] i_value,
    input  logic        i_direction,
    // byte channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spcf_pkg::*;

    // --- config register ---
    logic [3:0] r_pump_address;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_PUMP_ADDR) ? {28'd0, r_pump_address} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump_address <= PUMP_ADDR_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_PUMP_ADDR) begin
            r_pump_address <= pwdata[3:0];
        end
    end

    // --- command register ---
    logic        r_cmd_valid;
    logic        n_cmd_valid;
    logic [3:0]  r_action;
    logic [11:0] r_value;
    logic        r_direction;
    logic        w_in_fire;
    logic        w_move;
    logic        w_load_valid;
    logic        w_load_ready;
    t_frame      w_frame;

    // Frame is built from the registered command; an empty frame is dropped.
    spcf_builder u_builder (
        .i_action       (r_action),
        .i_value        (r_value),
        .i_direction    (r_direction),
        .i_pump_address (r_pump_address),
        .o_frame        (w_frame)
    );

    assign w_load_valid = r_cmd_valid && (w_frame.len != '0);
    assign w_move       = r_cmd_valid && ((w_frame.len == '0) || w_load_ready);
    assign o_in_ready   = !r_cmd_valid || w_move;
    assign w_in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_cmd_valid = r_cmd_valid;
        priority if (w_in_fire) begin
            n_cmd_valid = 1'b1;
        end else if (w_move) begin
            n_cmd_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else begin
            r_cmd_valid <= n_cmd_valid;
        end
        if (w_in_fire) begin
            r_action    <= i_action;
            r_value     <= i_value;
            r_direction <= i_direction;
        end
    end

    // --- byte shifter ---
    spcf_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (w_load_valid),
        .i_frame      (w_frame),
        .o_load_ready (w_load_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_tx_byte    (o_tx_byte),
        .o_last_byte  (o_last_byte)
    );

    // --- checks ---
`include "syringe_pump_command_framer_defines.svh"

    // the end-of-frame beat is always the line feed
    `SPCF_ASSERT_IMPL(a_last_is_lf, i_clk, i_rst_n, o_out_valid && o_last_byte,
        o_tx_byte == ASCII_LF)
    // no line feed appears inside a frame body
    `SPCF_ASSERT_IMPL(a_body_no_lf, i_clk, i_rst_n, o_out_valid && !o_last_byte,
        o_tx_byte != ASCII_LF)
    // a blocked command holds in its register
    `SPCF_ASSERT_NEXT(a_cmd_holds, i_clk, i_rst_n, r_cmd_valid && !w_move,
        r_cmd_valid && $stable(r_action) && $stable(r_value))

endmodule
